// ----- sv/psfd_pkg.sv -----
// Shared types and constants of the per-source flood detector.
package psfd_pkg;

  localparam int ADDR_W   = 32;
  localparam int TIME_W   = 32;
  localparam int CNT_W    = 16;
  localparam int LIMIT_W  = 16;
  localparam int BUCKET_W = 10;
  localparam int PDATA_W  = 32;
  localparam int PADDR_W  = 3;

  localparam logic [31:0]      HASH_MULT       = 32'd65599;
  localparam logic [LIMIT_W-1:0] TIME_LIMIT_RST  = 16'd10;
  localparam logic [LIMIT_W-1:0] COUNT_LIMIT_RST = 16'd100;
  localparam logic [CNT_W-1:0]   CNT_MAX         = '1;

  typedef enum logic [1:0] {
    ST_ACCEPT = 2'd0,
    ST_FLOOD  = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  typedef enum logic {
    REG_TIME_LIMIT  = 1'b0,
    REG_COUNT_LIMIT = 1'b1
  } reg_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_HASH,
    S_READ
  } state_e;

  typedef struct packed {
    logic [LIMIT_W-1:0] time_limit;
    logic [LIMIT_W-1:0] count_limit;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    logic [ADDR_W-1:0]  addr;
    logic [CNT_W-1:0]   count;
    logic [TIME_W-1:0]  tstamp;
  } entry_t;

endpackage

// ----- sv/per_source_flood_detector.sv -----
// Per-source flood detector: packet events in, one status and bucket per event out.
//
// Input channel: src_addr_i and now_sec_i with in_valid_i; the block holds in_stall_o
// high while it works on a transfer or clears its table. Output channel: status_o and
// bucket_o with out_valid_o; the receiver holds out_stall_i high to keep a result.
// Configuration goes through the APB port: time_limit at byte address 0 and
// count_limit at byte address 4. The user must write them only while the block is
// idle; the block does not enforce this. Each transfer is accepted, then passes
// through the hash unit (four sdbm byte steps, then a reciprocal multiply, a
// multiply-subtract and a correction for the remainder by the bucket count), a
// memory read of the bucket row and a final step that updates the row, writes it
// back and loads the output register.
// The next input is taken while a result waits in the output register; if the
// receiver still stalls when the following result is ready, the block waits with
// that row held until the output register frees up.
// After reset the table is cleared one bucket row per cycle, all BUCKETS rows,
// with in_stall_o high; configuration writes are taken during the sweep.
module per_source_flood_detector #(
  parameter int BUCKETS = 1024,
  parameter int WAYS    = 4
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [psfd_pkg::ADDR_W-1:0]      src_addr_i,
  input  logic [psfd_pkg::TIME_W-1:0]      now_sec_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [1:0]                       status_o,
  output logic [psfd_pkg::BUCKET_W-1:0]    bucket_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [psfd_pkg::PADDR_W-1:0]     paddr,
  input  logic [psfd_pkg::PDATA_W-1:0]     pwdata,
  output logic [psfd_pkg::PDATA_W-1:0]     prdata,
  output logic                             pready
);
  import psfd_pkg::*;

  localparam int BktW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

  state_e            state_q, state_d;
  cfg_t              cfg_q, cfg_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [TIME_W-1:0] now_q, now_d;
  logic              out_valid_q, out_valid_d;
  status_e           status_q, status_d;
  logic [BUCKET_W-1:0] bucket_q, bucket_d;

  logic              accept;
  logic              hash_start;
  logic              hash_done;
  logic [BktW-1:0]   hash_bkt;
  logic [31:0]       bkt_ext;
  logic              tbl_clearing;
  logic              rd_en, wr_en;
  entry_t [WAYS-1:0] rd_row, wr_row;
  status_e           upd_status;
  logic              out_free;
  logic              cfg_we;
  reg_e              cfg_sel;

  psfd_hash #(.BUCKETS(BUCKETS)) u_hash (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (hash_start),
    .addr_i   (src_addr_i),
    .done_o   (hash_done),
    .bucket_o (hash_bkt)
  );

  psfd_table #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (rd_en),
    .rd_addr_i  (hash_bkt),
    .rd_data_o  (rd_row),
    .wr_en_i    (wr_en),
    .wr_addr_i  (hash_bkt),
    .wr_data_i  (wr_row),
    .clearing_o (tbl_clearing)
  );

  psfd_update #(.WAYS(WAYS)) u_update (
    .row_i    (rd_row),
    .addr_i   (addr_q),
    .now_i    (now_q),
    .cfg_i    (cfg_q),
    .row_o    (wr_row),
    .status_o (upd_status)
  );

  assign in_stall_o = (state_q != S_IDLE) || tbl_clearing;
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign bkt_ext    = 32'(hash_bkt);

  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    now_d       = now_q;
    hash_start  = 1'b0;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    status_d    = status_q;
    bucket_d    = bucket_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          addr_d     = src_addr_i;
          now_d      = now_sec_i;
          hash_start = 1'b1;
          state_d    = S_HASH;
        end
      end
      S_HASH: begin
        if (hash_done) begin
          rd_en   = 1'b1;
          state_d = S_READ;
        end
      end
      S_READ: begin
        if (out_free) begin
          wr_en       = 1'b1;
          status_d    = upd_status;
          bucket_d    = bkt_ext[BUCKET_W-1:0];
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_sel = reg_e'(paddr[2]);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we) begin
      unique case (cfg_sel)
        REG_TIME_LIMIT:  cfg_d.time_limit  = pwdata[LIMIT_W-1:0];
        REG_COUNT_LIMIT: cfg_d.count_limit = pwdata[LIMIT_W-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_TIME_LIMIT:  prdata = PDATA_W'(cfg_q.time_limit);
      REG_COUNT_LIMIT: prdata = PDATA_W'(cfg_q.count_limit);
      default:         prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= S_IDLE;
      out_valid_q       <= 1'b0;
      cfg_q.time_limit  <= TIME_LIMIT_RST;
      cfg_q.count_limit <= COUNT_LIMIT_RST;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cfg_q       <= cfg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q   <= addr_d;
    now_q    <= now_d;
    status_q <= status_d;
    bucket_q <= bucket_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign bucket_o    = bucket_q;

`ifndef SYNTHESIS
  a_done_in_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hash_done |-> state_q == S_HASH)
    else $error("hash result outside the hash phase");
  a_result_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_READ))
    else $error("result loaded outside row update");
  a_read_completes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ && !out_valid_q) |=> out_valid_q && state_q == S_IDLE)
    else $error("row update did not complete with a free output register");
`endif

endmodule

// ----- sv/psfd_hash.sv -----
// Iterative sdbm hash over the address bytes followed by a remainder by the bucket count.
module psfd_hash #(
  parameter int BUCKETS = 1024,
  localparam int BktW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [psfd_pkg::ADDR_W-1:0]   addr_i,
  output logic                          done_o,
  output logic [BktW-1:0]               bucket_o
);
  import psfd_pkg::*;

  localparam logic [2:0]  MulStep  = 3'd4;
  localparam logic [2:0]  SubStep  = 3'd5;
  localparam logic [2:0]  LastStep = 3'd6;
  localparam logic [32:0] Recip    = 33'((64'd1 << 32) / 64'(BUCKETS));
  localparam logic [31:0] BktDiv   = 32'(BUCKETS);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [2:0]        step_q, step_d;
  logic [31:0]       n_q, n_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [31:0]       quot_q, quot_d;
  logic [31:0]       diff_q, diff_d;
  logic [BktW-1:0]   rem_q, rem_d;
  logic [31:0]       hash_next;
  logic [63:0]       prod;
  logic [31:0]       quot_next;
  logic [31:0]       diff_next;
  logic [BktW-1:0]   rem_next;

  always_comb begin
    logic [31:0] sext;
    sext      = {{24{addr_q[7]}}, addr_q[7:0]};
    hash_next = sext + (n_q << 16) + (n_q << 6) - n_q;
  end

  // The reciprocal estimate is at most one below the true quotient, so a single
  // compare and subtract completes the remainder.
  assign prod      = 64'(n_q) * 64'(Recip);
  assign quot_next = prod[63:32];
  assign diff_next = n_q - quot_q * BktDiv;

  always_comb begin
    logic [31:0] red;
    red      = (diff_q >= BktDiv) ? diff_q - BktDiv : diff_q;
    rem_next = red[BktW-1:0];
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    n_d    = n_q;
    addr_d = addr_q;
    quot_d = quot_q;
    diff_d = diff_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      n_d    = '0;
      addr_d = addr_i;
      rem_d  = '0;
    end else if (busy_q) begin
      step_d = step_q + 3'd1;
      if (!step_q[2]) begin
        n_d    = hash_next;
        addr_d = addr_q >> 8;
      end else if (step_q == MulStep) begin
        quot_d = quot_next;
      end else if (step_q == SubStep) begin
        diff_d = diff_next;
      end else begin
        rem_d = rem_next;
      end
      if (step_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    addr_q <= addr_d;
    quot_q <= quot_d;
    diff_q <= diff_d;
    rem_q  <= rem_d;
  end

  assign done_o   = done_q;
  assign bucket_o = rem_q;

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("hash started while busy");
`endif

endmodule

// ----- sv/psfd_table.sv -----
// Bucket memory with one row of ways per bucket and a clearing sweep after reset.
module psfd_table #(
  parameter int BUCKETS = 1024,
  parameter int WAYS    = 4,
  localparam int BktW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               rd_en_i,
  input  logic [BktW-1:0]                    rd_addr_i,
  output psfd_pkg::entry_t [WAYS-1:0]        rd_data_o,
  input  logic                               wr_en_i,
  input  logic [BktW-1:0]                    wr_addr_i,
  input  psfd_pkg::entry_t [WAYS-1:0]        wr_data_i,
  output logic                               clearing_o
);
  import psfd_pkg::*;

  localparam logic [BktW-1:0] LastRow = BktW'(BUCKETS - 1);

  entry_t [WAYS-1:0] mem [BUCKETS];
  entry_t [WAYS-1:0] rd_q;
  entry_t [WAYS-1:0] mem_wdata;
  logic              clearing_q, clearing_d;
  logic [BktW-1:0]   clr_q, clr_d;
  logic              mem_we;
  logic [BktW-1:0]   mem_waddr;

  always_comb begin
    clearing_d = clearing_q;
    clr_d      = clr_q;
    mem_we     = wr_en_i;
    mem_waddr  = wr_addr_i;
    mem_wdata  = wr_data_i;
    if (clearing_q) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
      clr_d     = clr_q + BktW'(1);
      if (clr_q == LastRow) begin
        clearing_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_q      <= '0;
    end else begin
      clearing_q <= clearing_d;
      clr_q      <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o  = rd_q;
  assign clearing_o = clearing_q;

`ifndef SYNTHESIS
  a_no_wr_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_i |-> !clearing_q)
    else $error("row write during clearing sweep");
  a_no_rd_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en_i |-> !clearing_q)
    else $error("row read during clearing sweep");
`endif

endmodule

// ----- sv/psfd_update.sv -----
// Way match, free-way search and entry update for one bucket row.
module psfd_update #(
  parameter int WAYS = 4
) (
  input  psfd_pkg::entry_t [WAYS-1:0]     row_i,
  input  logic [psfd_pkg::ADDR_W-1:0]     addr_i,
  input  logic [psfd_pkg::TIME_W-1:0]     now_i,
  input  psfd_pkg::cfg_t                  cfg_i,
  output psfd_pkg::entry_t [WAYS-1:0]     row_o,
  output psfd_pkg::status_e               status_o
);
  import psfd_pkg::*;

  localparam int WayW = (WAYS > 1) ? $clog2(WAYS) : 1;

  logic            hit, free;
  logic [WayW-1:0] hit_idx, free_idx;
  entry_t          hit_e;
  logic [TIME_W-1:0] age;
  logic            expired;
  logic [CNT_W-1:0]  cnt_inc;
  logic            flood;

  always_comb begin
    hit      = 1'b0;
    free     = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (row_i[w].valid) begin
        if (!hit && row_i[w].addr == addr_i) begin
          hit     = 1'b1;
          hit_idx = WayW'(w);
        end
      end else if (!free) begin
        free     = 1'b1;
        free_idx = WayW'(w);
      end
    end
  end

  assign hit_e   = row_i[hit_idx];
  assign age     = now_i - hit_e.tstamp;
  assign expired = age > TIME_W'(cfg_i.time_limit);
  assign cnt_inc = (hit_e.count == CNT_MAX) ? CNT_MAX : hit_e.count + CNT_W'(1);
  assign flood   = cnt_inc >= cfg_i.count_limit;

  always_comb begin
    row_o    = row_i;
    status_o = ST_ACCEPT;
    if (hit) begin
      if (expired) begin
        row_o[hit_idx].count  = '0;
        row_o[hit_idx].tstamp = now_i;
      end else begin
        row_o[hit_idx].count = cnt_inc;
        if (flood) begin
          row_o[hit_idx].valid = 1'b0;
          status_o             = ST_FLOOD;
        end
      end
    end else if (free) begin
      row_o[free_idx].valid  = 1'b1;
      row_o[free_idx].addr   = addr_i;
      row_o[free_idx].count  = CNT_W'(1);
      row_o[free_idx].tstamp = now_i;
    end else begin
      status_o = ST_FULL;
    end
  end

endmodule

// ----- tb/psfd_verdict_check.sv -----
// Checker that predicts the flood detector's verdict for each packet and compares every result.
`timescale 1ns / 100ps
module psfd_verdict_check #(
  parameter int BUCKETS = 1024,
  parameter int WAYS    = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [psfd_pkg::ADDR_W-1:0]   src_addr_i,
  input  logic [psfd_pkg::TIME_W-1:0]   now_sec_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [1:0]                    status_i,
  input  logic [psfd_pkg::BUCKET_W-1:0] bucket_i,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [psfd_pkg::PADDR_W-1:0]  paddr_i,
  input  logic [psfd_pkg::PDATA_W-1:0]  pwdata_i,
  input  logic                          pready_i,
  output int                            failures_o,
  output int                            due_o
);
  import psfd_pkg::*;

  localparam int SLOTS = BUCKETS * WAYS;

  typedef struct packed {
    status_e             status;
    logic [BUCKET_W-1:0] bucket;
  } verdict_t;

  bit                 held [SLOTS];
  logic [ADDR_W-1:0]  held_addr [SLOTS];
  logic [CNT_W-1:0]   held_count [SLOTS];
  logic [TIME_W-1:0]  held_time [SLOTS];
  logic [LIMIT_W-1:0] window_len  = TIME_LIMIT_RST;
  logic [LIMIT_W-1:0] flood_count = COUNT_LIMIT_RST;
  verdict_t           verdicts_due [$];
  int                 fails   = 0;
  int                 pending = 0;

  assign failures_o = fails;
  assign due_o      = pending;

  function automatic logic [31:0] sdbm_hash(input logic [ADDR_W-1:0] a);
    logic [31:0] n;
    logic [31:0] b;
    n = '0;
    for (int i = 0; i < 4; i++) begin
      b = {{24{a[8*i+7]}}, a[8*i +: 8]};
      n = b + HASH_MULT * n;
    end
    return n;
  endfunction

  function automatic verdict_t classify_packet(input logic [ADDR_W-1:0] a,
                                               input logic [TIME_W-1:0] t);
    logic [31:0]       bkt;
    logic [TIME_W-1:0] age;
    int                hit;
    int                spare;
    int                s;
    int                w;
    verdict_t          v;
    bkt      = sdbm_hash(a) % 32'(BUCKETS);
    hit      = -1;
    spare    = -1;
    v.status = ST_ACCEPT;
    v.bucket = bkt[BUCKET_W-1:0];
    for (w = 0; w < WAYS; w++) begin
      s = int'(bkt) * WAYS + w;
      if (held[s]) begin
        if (hit < 0 && held_addr[s] == a) hit = s;
      end else if (spare < 0) begin
        spare = s;
      end
    end
    if (hit >= 0) begin
      age = t - held_time[hit];
      if (age > TIME_W'(window_len)) begin
        held_count[hit] = '0;
        held_time[hit]  = t;
      end else begin
        if (held_count[hit] != CNT_MAX) held_count[hit] = held_count[hit] + 1'b1;
        if (held_count[hit] >= flood_count) begin
          held[hit] = 1'b0;
          v.status  = ST_FLOOD;
        end
      end
    end else if (spare >= 0) begin
      held[spare]       = 1'b1;
      held_addr[spare]  = a;
      held_count[spare] = CNT_W'(1);
      held_time[spare]  = t;
    end else begin
      v.status = ST_FULL;
    end
    return v;
  endfunction

  always @(posedge clk_i) begin : watch_transfers
    verdict_t want;
    if (rst_ni) begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i[PADDR_W-1:2] == REG_TIME_LIMIT) begin
          window_len = pwdata_i[LIMIT_W-1:0];
        end else if (paddr_i[PADDR_W-1:2] == REG_COUNT_LIMIT) begin
          flood_count = pwdata_i[LIMIT_W-1:0];
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (verdicts_due.size() == 0) begin
          fails++;
          $display("%0t: result with none expected, status %0d bucket %0d",
                   $time, status_i, bucket_i);
        end else begin
          want = verdicts_due.pop_front();
          if (status_i !== want.status) begin
            fails++;
            $display("%0t: status expected %0d, got %0d", $time, want.status, status_i);
          end
          if (bucket_i !== want.bucket) begin
            fails++;
            $display("%0t: bucket expected %0d, got %0d", $time, want.bucket, bucket_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        verdicts_due.push_back(classify_packet(src_addr_i, now_sec_i));
      end
      pending = verdicts_due.size();
    end
  end

endmodule

// ----- tb/per_source_flood_detector_test.sv -----
// Testbench top of the flood detector: clock, reset, packet and register stimulus, verdict.
`timescale 1ns / 100ps
module per_source_flood_detector_test;
  import psfd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 280;

  localparam logic [PHASES-1:0][15:0] WINDOW_PLAN =
    {16'd1, 16'd65535, 16'd20, 16'd65535, 16'd0, 16'd3};
  localparam logic [PHASES-1:0][15:0] FLOOD_PLAN =
    {16'd100, 16'd2, 16'd8, 16'd65535, 16'd1, 16'd4};

  logic                clk      = 1'b0;
  logic                rst_n    = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [ADDR_W-1:0]   src_addr = '0;
  logic [TIME_W-1:0]   now_sec  = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [1:0]          status;
  logic [BUCKET_W-1:0] bucket;
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [PADDR_W-1:0]  paddr   = '0;
  logic [PDATA_W-1:0]  pwdata  = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  int                  failures;
  int                  due;
  int                  cycles       = 0;
  int                  holdoff_asks = 0;
  bit                  steady       = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  per_source_flood_detector dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .src_addr_i  (src_addr),
    .now_sec_i   (now_sec),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .status_o    (status),
    .bucket_o    (bucket),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  psfd_verdict_check watch (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .src_addr_i  (src_addr),
    .now_sec_i   (now_sec),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .status_i    (status),
    .bucket_i    (bucket),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .pready_i    (pready),
    .failures_o  (failures),
    .due_o       (due)
  );

  // Raising the top two bytes together by 16 leaves the bucket unchanged.
  function automatic logic [ADDR_W-1:0] bucket_mate(input logic [ADDR_W-1:0] base,
                                                    input int k);
    return {4'(k), base[27:24], 4'(k), base[19:16], base[15:0]};
  endfunction

  task automatic send_packet(input logic [ADDR_W-1:0] a, input logic [TIME_W-1:0] t);
    while (!steady && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    src_addr <= a;
    now_sec  <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_reg(input reg_e r, input logic [LIMIT_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({r, 2'b00});
    pwdata  <= {16'($urandom), val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // The block must be idle before a register write and before the verdict.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[per_source_flood_detector] ERROR");
      $finish;
    end
  end

  initial begin : receiver
    int hold_left;
    int served;
    hold_left = 0;
    served    = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (served != holdoff_asks) begin
        served++;
        hold_left = 299;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !steady && ($urandom_range(99) < 10);
      end
    end
  end

  initial begin : stimulus
    logic [ADDR_W-1:0] sources [16];
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] a;
    logic [TIME_W-1:0] t;
    logic [TIME_W-1:0] clock_s;
    int                n_src;
    int                r;
    int                p;
    int                i;
    int                k;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset window of 10 s and flood count of 100.
    send_packet(32'h0000_0000, 32'h0000_1000);
    send_packet(32'hFFFF_FFFF, 32'h0000_1000);
    send_packet(32'h0000_0000, 32'h0000_100A);
    send_packet(32'h0000_0000, 32'h0000_1015);
    send_packet(32'h8080_8080, 32'hFFFF_FFFE);
    send_packet(32'h8080_8080, 32'h0000_0003);
    send_packet(32'h7F7F_7F7F, 32'hFFFF_FFFF);
    base = 32'h1234_5678;
    for (k = 0; k < 5; k++) send_packet(bucket_mate(base, k), 32'h0000_2000);
    send_packet(bucket_mate(base, 2), 32'h0000_2001);

    // Zero window and a flood count of one: any repeat in the same second floods.
    settle();
    write_reg(REG_TIME_LIMIT, 16'd0);
    write_reg(REG_COUNT_LIMIT, 16'd1);
    send_packet(bucket_mate(base, 1), 32'h0000_2000);
    send_packet(bucket_mate(base, 4), 32'h0000_2000);
    send_packet(bucket_mate(base, 4), 32'h0000_2000);
    send_packet(bucket_mate(base, 0), 32'h0000_2005);
    send_packet(bucket_mate(base, 0), 32'h0000_2005);
    send_packet(32'h0000_0000, 32'h0000_1015);

    for (p = 0; p < PHASES; p++) begin
      settle();
      write_reg(REG_TIME_LIMIT, WINDOW_PLAN[p]);
      write_reg(REG_COUNT_LIMIT, FLOOD_PLAN[p]);
      base  = $urandom;
      n_src = 6 + $urandom_range(8, 2);
      for (k = 0; k < 6; k++) sources[k] = bucket_mate(base, k);
      for (k = 6; k < n_src; k++) sources[k] = $urandom;
      clock_s = p[0] ? 32'hFFFF_FF00 + $urandom_range(255, 0) : $urandom;
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if (i == 40 && p < 2) holdoff_asks++;
        steady = (p == 2 && i < 150);
        r = $urandom_range(99);
        if (r < 12) begin
          a = $urandom;
          t = $urandom;
        end else begin
          a = sources[$urandom_range(n_src - 1)];
          if (r < 15) begin
            clock_s = clock_s + $urandom_range(2 * WINDOW_PLAN[p] + 2, 0);
          end else if (r < 20) begin
            clock_s = clock_s + 1;
          end
          t = (r == 99) ? clock_s - $urandom_range(1000, 1) : clock_s;
        end
        send_packet(a, t);
      end
    end
    steady = 1'b0;

    settle();
    if (failures == 0) begin
      $display("[per_source_flood_detector] OK");
    end else begin
      $display("[per_source_flood_detector] ERROR");
    end
    $finish;
  end

endmodule
